FILE: hdl/dlt_pkg.sv
// ----------------------------------------------------------------------------
// dlt_pkg
// shared types and constants of the longest-match dfa tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package dlt_pkg;

  localparam int unsigned DfaRows      = 256;
  localparam int unsigned AlphabetSize = 256;
  localparam int unsigned MaxLexeme    = 32;
  localparam int unsigned ClassCount   = 64;

  typedef enum logic [1:0] {
    ACT_FEED  = 2'd0,
    ACT_TRANS = 2'd1,
    ACT_CLASS = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] symbol;
    logic [7:0] row;
    logic [7:0] target_row;
    logic       target_valid;
    logic [5:0] class_code;
    logic       end_of_input;
  } in_req_t;

  typedef struct packed {
    logic [5:0]  token_class;
    logic        is_error;
    logic [15:0] token_start;
    logic [5:0]  token_length;
    logic        last_of_run;
  } out_req_t;

endpackage

`default_nettype wire

FILE: hdl/dlt_ram.sv
// ----------------------------------------------------------------------------
// dlt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dfa_longest_match_tokenizer.sv
// ----------------------------------------------------------------------------
// dfa_longest_match_tokenizer
// maximal munch lexer; transitions, accepting classes and the lexeme window
// live in rams, a sequencer steps one character per pass
// ----------------------------------------------------------------------------
// a character with no token runs a pass (window read, transition read, accept read,
// update), then a final check, then idle; table writes are taken while idle
// a pass that finds no move emits a token once the output can take it and rescans,
// an end-of-input cut is made in the final check; stall is held while busy
// a token leaves at the next cut or at the end of its request; a full output stalls
// reset clears all control state; the rams hold nothing until written
`default_nettype none

module dfa_longest_match_tokenizer
  import dlt_pkg::*;
#(
  parameter int unsigned DFA_ROWS      = DfaRows,
  parameter int unsigned ALPHABET_SIZE = AlphabetSize,
  parameter int unsigned MAX_LEXEME    = MaxLexeme,
  parameter int unsigned CLASS_COUNT   = ClassCount
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_req_t      out_req_o
);

  localparam int unsigned RW  = $clog2(DFA_ROWS);
  localparam int unsigned SW  = $clog2(ALPHABET_SIZE);
  localparam int unsigned TAW = RW + SW;
  localparam int unsigned PW  = $clog2(MAX_LEXEME + 1);
  localparam int unsigned WD  = 1 << PW;
  localparam int unsigned CW  = $clog2(MAX_LEXEME + 2);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_TRANS = 5'b01000,
    ST_ACC   = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [7:0]      start_row_q;
  logic [7:0]      cur_q, cur_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   avail_q, avail_d;
  logic [CW-1:0]   best_len_q, best_len_d;
  logic [5:0]      best_cls_q, best_cls_d;
  logic [15:0]     pos_q, pos_d;
  logic [PW-1:0]   head_q, head_d;
  logic            eoi_q, eoi_d;
  logic            ok_q, ok_d;
  out_req_t        pend_q, pend_d;
  logic            pend_v_q, pend_v_d;
  out_req_t        out_q, out_d;
  logic            out_v_q, out_v_d;

  logic            in_acc;
  logic            out_free, can_emit, emit_en, flush_en;
  logic [CW-1:0]   cut_len;
  out_req_t        tok;
  logic [7:0]      scan_row;

  logic            tr_we, tr_re;
  logic [TAW-1:0]  tr_waddr, tr_raddr;
  logic [8:0]      tr_rdata;
  logic            ac_we, ac_re;
  logic [RW-1:0]   ac_waddr, ac_raddr;
  logic [5:0]      ac_wdata, ac_rdata;
  logic            wn_we, wn_re;
  logic [PW-1:0]   wn_waddr, wn_raddr;
  logic [7:0]      wn_rdata;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_v_q;
  assign out_req_o   = out_q;

  // table writes
  assign tr_we    = in_acc && (in_req_i.action == ACT_TRANS)
                    && (32'(in_req_i.row) < DFA_ROWS) && (32'(in_req_i.symbol) < ALPHABET_SIZE);
  assign tr_waddr = {RW'(in_req_i.row), SW'(in_req_i.symbol)};
  assign ac_we    = in_acc && (in_req_i.action == ACT_CLASS) && (32'(in_req_i.row) < DFA_ROWS);
  assign ac_waddr = RW'(in_req_i.row);
  assign ac_wdata = (32'(in_req_i.class_code) < CLASS_COUNT) ? in_req_i.class_code : 6'd0;

  // lexeme window
  assign wn_we    = in_acc && (in_req_i.action == ACT_FEED);
  assign wn_waddr = head_q + PW'(avail_q);
  assign wn_re    = (state_q == ST_FETCH) && (count_q < avail_q);
  assign wn_raddr = head_q + PW'(count_q);

  assign scan_row = (count_q != '0) ? cur_q : start_row_q;
  assign tr_re    = (state_q == ST_LOOK);
  assign tr_raddr = {RW'(scan_row), SW'(wn_rdata)};
  assign ac_re    = (state_q == ST_TRANS) && ok_q && tr_rdata[8];
  assign ac_raddr = RW'(tr_rdata[7:0]);

  assign out_free = !out_v_q || !out_stall_i;
  assign can_emit = !pend_v_q || out_free;
  assign cut_len  = (best_len_q != '0) ? best_len_q : CW'(1);

  always_comb begin
    tok.token_class  = (best_len_q != '0) ? best_cls_q : 6'd0;
    tok.is_error     = (best_len_q == '0);
    tok.token_start  = pos_q;
    tok.token_length = 6'(cut_len);
    tok.last_of_run  = 1'b0;
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    count_d    = count_q;
    avail_d    = avail_q;
    best_len_d = best_len_q;
    best_cls_d = best_cls_q;
    pos_d      = pos_q;
    head_d     = head_q;
    eoi_d      = eoi_q;
    ok_d       = ok_q;
    emit_en    = 1'b0;
    flush_en   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_req_i.action == ACT_FEED)) begin
          avail_d = avail_q + CW'(1);
          eoi_d   = in_req_i.end_of_input;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (count_q < avail_q) begin
          state_d = ST_LOOK;
        end else if (eoi_q && (count_q != '0)) begin
          emit_en = can_emit;
        end else if (can_emit) begin
          flush_en = pend_v_q;
          if (eoi_q) begin
            pos_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      ST_LOOK: begin
        ok_d    = (count_q < CW'(MAX_LEXEME)) && (32'(scan_row) < DFA_ROWS)
                  && (32'(wn_rdata) < ALPHABET_SIZE);
        state_d = ST_TRANS;
      end
      ST_TRANS: begin
        if (ok_q && tr_rdata[8]) begin
          state_d = ST_ACC;
        end else begin
          emit_en = can_emit;
        end
      end
      ST_ACC: begin
        count_d = count_q + CW'(1);
        cur_d   = tr_rdata[7:0];
        if ((32'(tr_rdata[7:0]) < DFA_ROWS) && (ac_rdata != 6'd0)) begin
          best_len_d = count_q + CW'(1);
          best_cls_d = ac_rdata;
        end
        state_d = ST_FETCH;
      end
      default: state_d = ST_IDLE;
    endcase
    // token cut, also the error token when nothing was accepted
    if (emit_en) begin
      pos_d      = pos_q + 16'(cut_len);
      head_d     = head_q + PW'(cut_len);
      avail_d    = avail_q - cut_len;
      count_d    = '0;
      best_len_d = '0;
      best_cls_d = '0;
      state_d    = ST_FETCH;
    end
  end

  always_comb begin
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && out_stall_i;
    if (emit_en) begin
      pend_d   = tok;
      pend_v_d = 1'b1;
      if (pend_v_q) begin
        out_d   = pend_q;
        out_v_d = 1'b1;
      end
    end else if (flush_en) begin
      out_d             = pend_q;
      out_d.last_of_run = 1'b1;
      out_v_d           = 1'b1;
      pend_v_d          = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_row_q <= '0;
      cur_q       <= '0;
      count_q     <= '0;
      avail_q     <= '0;
      best_len_q  <= '0;
      best_cls_q  <= '0;
      pos_q       <= '0;
      head_q      <= '0;
      eoi_q       <= 1'b0;
      ok_q        <= 1'b0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        start_row_q <= cfg_wdata_i;
      end
      cur_q      <= cur_d;
      count_q    <= count_d;
      avail_q    <= avail_d;
      best_len_q <= best_len_d;
      best_cls_q <= best_cls_d;
      pos_q      <= pos_d;
      head_q     <= head_d;
      eoi_q      <= eoi_d;
      ok_q       <= ok_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  dlt_ram #(.WIDTH(9), .DEPTH(DFA_ROWS << SW)) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i ({in_req_i.target_valid, in_req_i.target_row}),
    .re_i    (tr_re),
    .raddr_i (tr_raddr),
    .rdata_o (tr_rdata)
  );

  dlt_ram #(.WIDTH(6), .DEPTH(DFA_ROWS)) u_accept_ram (
    .clk_i   (clk_i),
    .we_i    (ac_we),
    .waddr_i (ac_waddr),
    .wdata_i (ac_wdata),
    .re_i    (ac_re),
    .raddr_i (ac_raddr),
    .rdata_o (ac_rdata)
  );

  dlt_ram #(.WIDTH(8), .DEPTH(WD)) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (wn_we),
    .waddr_i (wn_waddr),
    .wdata_i (in_req_i.symbol),
    .re_i    (wn_re),
    .raddr_i (wn_raddr),
    .rdata_o (wn_rdata)
  );

endmodule

`default_nettype wire
